@@ hw/rtl/qte_pkg.sv @@
// Package for the quaternion to Euler angle converter.
// Holds the fixed-point widths, angle constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package qte_pkg;

  localparam int unsigned IN_W      = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned TERM_W    = 35;   // exact Q28 product terms
  localparam int unsigned RAD_W     = 58;   // square root radicand and work registers
  localparam int unsigned SQRT_W    = 29;   // floor(sqrt(2^56 - s^2)) fits here
  localparam int unsigned SQRT_STEPS = 29;  // one result bit per stage
  localparam int unsigned SIN_W     = 29;   // unsaturated arcsine argument
  localparam int unsigned CW        = 37;   // CORDIC x/y width, covers gain growth
  localparam int unsigned ZW        = 29;   // CORDIC angle, Q24 radians
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic signed [TERM_W-1:0] ONE_Q28     = TERM_W'(64'sd268435456);
  localparam logic signed [ZW-1:0]     PI_Q24      = ZW'(64'sd52707179);
  localparam logic signed [ZW-1:0]     PI_Q13      = ZW'(64'sd25736);
  localparam logic signed [ZW-1:0]     HALF_PI_Q13 = ZW'(64'sd12868);
  localparam logic signed [ZW-1:0]     ROUND_HALF  = ZW'(64'sd1024);

  localparam logic signed [ZW-1:0] ATAN_Q24 [ATAN_LEN] = '{
    ZW'(64'sd13176795), ZW'(64'sd7778716), ZW'(64'sd4110060), ZW'(64'sd2086331),
    ZW'(64'sd1047214),  ZW'(64'sd524117),  ZW'(64'sd262123),  ZW'(64'sd131069),
    ZW'(64'sd65536),    ZW'(64'sd32768),   ZW'(64'sd16384),   ZW'(64'sd8192),
    ZW'(64'sd4096),     ZW'(64'sd2048),    ZW'(64'sd1024),    ZW'(64'sd512),
    ZW'(64'sd256),      ZW'(64'sd128),     ZW'(64'sd64),      ZW'(64'sd32),
    ZW'(64'sd16),       ZW'(64'sd8),       ZW'(64'sd4),       ZW'(64'sd2)
  };

  // Terms that ride alongside the square root pipeline.
  typedef struct packed {
    logic signed [TERM_W-1:0] sinr;
    logic signed [TERM_W-1:0] cosr;
    logic signed [TERM_W-1:0] siny;
    logic signed [TERM_W-1:0] cosy;
    logic signed [SIN_W-1:0]  sinp;
    logic                     sat_pos;
    logic                     sat_neg;
  } qte_side_t;

endpackage

@@ hw/rtl/qte_isqrt.sv @@
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word in step with the data. Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_isqrt import qte_pkg::*; #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [RAD_W-1:0]  rad_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [SQRT_W-1:0] root_o,
  output logic [SIDE_W-1:0] side_o
);

  logic [RAD_W-1:0]  rem_q  [SQRT_STEPS];
  logic [RAD_W-1:0]  res_q  [SQRT_STEPS];
  logic [SIDE_W-1:0] side_q [SQRT_STEPS];
  logic              vld_q  [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
    localparam int unsigned K = SQRT_STEPS - 1 - j;
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (2 * K);
    logic [RAD_W-1:0]  rem_in, res_in, trial;
    logic [SIDE_W-1:0] side_in;
    logic              vld_in;

    if (j == 0) begin : g_first
      assign rem_in  = rad_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign res_in  = res_q[j-1];
      assign side_in = side_q[j-1];
      assign vld_in  = vld_q[j-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk_i) begin
      side_q[j] <= side_in;
      if (rem_in >= trial) begin
        rem_q[j] <= rem_in - trial;
        res_q[j] <= (res_in >> 1) + BIT;
      end else begin
        rem_q[j] <= rem_in;
        res_q[j] <= res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_in;
      end
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][SQRT_W-1:0];
  assign side_o  = side_q[SQRT_STEPS-1];

endmodule

@@ hw/rtl/qte_cordic.sv @@
// Pipelined vectoring CORDIC: four-quadrant arctangent in Q24 radians.
// One pre-rotation stage, then one register stage per iteration. Depends on qte_pkg.
`timescale 1ns / 1ps
module qte_cordic import qte_pkg::*; #(
  parameter int unsigned STEPS  = CORDIC_STEPS_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic signed [ZW-1:0] angle_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic signed [CW-1:0] x_q [STEPS+1];
  logic signed [CW-1:0] y_q [STEPS+1];
  logic signed [ZW-1:0] z_q [STEPS+1];
  logic                 zero_q [STEPS+1];
  logic [SIDE_W-1:0]    side_q [STEPS+1];
  logic                 vld_q  [STEPS+1];

  // Fold the left half plane over by pi; flag the null vector.
  always_ff @(posedge clk_i) begin
    zero_q[0] <= (x_i == '0) && (y_i == '0);
    side_q[0] <= side_i;
    if (x_i < 0) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      z_q[0] <= (y_i >= 0) ? PI_Q24 : -PI_Q24;
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      zero_q[i+1] <= zero_q[i];
      side_q[i+1] <= side_q[i];
      if (y_q[i] > 0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + ATAN_Q24[i];
      end else begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - ATAN_Q24[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  assign valid_o = vld_q[STEPS];
  assign angle_o = zero_q[STEPS] ? '0 : z_q[STEPS];
  assign side_o  = side_q[STEPS];

endmodule

@@ hw/rtl/quaternion_to_euler_core.sv @@
// Quaternion (Q2.14) to ZYX Euler angles (Q3.13, pitch Q2.13), fully pipelined.
// Throughput: one item per cycle; busy stays low, results cannot be held off.
// The depth is set by the 29-stage square root and the CORDIC iteration stages.
// Reset clears only the valid bits; the datapath registers carry no reset.
// Depends on qte_pkg, qte_isqrt and qte_cordic.
`timescale 1ns / 1ps
module quaternion_to_euler_core import qte_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [IN_W-1:0]  quat_w_i,
  input  logic signed [IN_W-1:0]  quat_x_i,
  input  logic signed [IN_W-1:0]  quat_y_i,
  input  logic signed [IN_W-1:0]  quat_z_i,
  output logic                    done_o,
  output logic signed [15:0]      roll_angle_o,
  output logic signed [14:0]      pitch_angle_o,
  output logic signed [15:0]      yaw_angle_o,
  output logic                    pitch_saturated_o
);

  localparam int unsigned LATENCY = 35 + CORDIC_STEPS;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Stage 0: capture the item.
  logic                   v0_q;
  logic signed [IN_W-1:0] w_q, x_q, y_q, z_q;

  always_ff @(posedge clk_i) begin
    w_q <= quat_w_i;
    x_q <= quat_x_i;
    y_q <= quat_y_i;
    z_q <= quat_z_i;
  end

  // Stage 1: the nine exact products, Q28.
  logic                     v1_q;
  logic signed [PROD_W-1:0] wx_q, yz_q, xx_q, yy_q, wy_q, zx_q, wz_q, xy_q, zz_q;

  always_ff @(posedge clk_i) begin
    wx_q <= w_q * x_q;
    yz_q <= y_q * z_q;
    xx_q <= x_q * x_q;
    yy_q <= y_q * y_q;
    wy_q <= w_q * y_q;
    zx_q <= z_q * x_q;
    wz_q <= w_q * z_q;
    xy_q <= x_q * y_q;
    zz_q <= z_q * z_q;
  end

  // Stage 2: sine and cosine terms of roll and yaw, sine term of pitch.
  logic                     v2_q;
  logic signed [TERM_W-1:0] sinr_q, cosr_q, sinp_q, siny_q, cosy_q;

  always_ff @(posedge clk_i) begin
    sinr_q <= (TERM_W'(wx_q) + TERM_W'(yz_q)) <<< 1;
    cosr_q <= ONE_Q28 - ((TERM_W'(xx_q) + TERM_W'(yy_q)) <<< 1);
    sinp_q <= (TERM_W'(wy_q) - TERM_W'(zx_q)) <<< 1;
    siny_q <= (TERM_W'(wz_q) + TERM_W'(xy_q)) <<< 1;
    cosy_q <= ONE_Q28 - ((TERM_W'(yy_q) + TERM_W'(zz_q)) <<< 1);
  end

  // Stage 3: clamp test and radicand 2^56 - s^2 for the arcsine cosine.
  logic                    v3_q;
  logic                    sat_pos, sat_neg;
  logic signed [SIN_W-1:0] sin_c;
  logic signed [RAD_W-1:0] sin_sq;
  logic [RAD_W-1:0]        rad_q;
  qte_side_t               side3_q;

  assign sat_pos = (sinp_q >= ONE_Q28);
  assign sat_neg = (sinp_q <= -ONE_Q28);
  assign sin_c   = (sat_pos || sat_neg) ? '0 : sinp_q[SIN_W-1:0];
  assign sin_sq  = sin_c * sin_c;

  always_ff @(posedge clk_i) begin
    rad_q           <= (RAD_W'(1) << 56) - RAD_W'(sin_sq);
    side3_q.sinr    <= sinr_q;
    side3_q.cosr    <= cosr_q;
    side3_q.siny    <= siny_q;
    side3_q.cosy    <= cosy_q;
    side3_q.sinp    <= sin_c;
    side3_q.sat_pos <= sat_pos;
    side3_q.sat_neg <= sat_neg;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Square root stages; the other terms ride along as sideband.
  logic              sq_vld;
  logic [SQRT_W-1:0] root;
  qte_side_t         side_sq;

  qte_isqrt #(
    .SIDE_W ($bits(qte_side_t))
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .rad_i   (rad_q),
    .side_i  (side3_q),
    .valid_o (sq_vld),
    .root_o  (root),
    .side_o  (side_sq)
  );

  // Three CORDIC lanes in lockstep; the pitch lane carries the clamp flags.
  logic                 cor_vld;
  logic signed [ZW-1:0] roll_z, pitch_z, yaw_z;
  logic [1:0]           sat_flags;

  qte_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (2)
  ) u_cordic_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .x_i     (CW'({1'b0, root})),
    .y_i     (CW'(side_sq.sinp)),
    .side_i  ({side_sq.sat_pos, side_sq.sat_neg}),
    .valid_o (cor_vld),
    .angle_o (pitch_z),
    .side_o  (sat_flags)
  );

  qte_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (1)
  ) u_cordic_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .x_i     (CW'(side_sq.cosr)),
    .y_i     (CW'(side_sq.sinr)),
    .side_i  (1'b0),
    .valid_o (),
    .angle_o (roll_z),
    .side_o  ()
  );

  qte_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W (1)
  ) u_cordic_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_vld),
    .x_i     (CW'(side_sq.cosy)),
    .y_i     (CW'(side_sq.siny)),
    .side_i  (1'b0),
    .valid_o (),
    .angle_o (yaw_z),
    .side_o  ()
  );

  // Output stage: round half up to Q13, clamp, apply the pitch clamp.
  logic signed [ZW-1:0] roll_r, pitch_r, yaw_r;
  logic signed [ZW-1:0] roll_c, pitch_c, yaw_c;
  logic                 done_q, sat_q;
  logic signed [15:0]   roll_q, yaw_q;
  logic signed [14:0]   pitch_q;

  assign roll_r  = (roll_z + ROUND_HALF) >>> 11;
  assign pitch_r = (pitch_z + ROUND_HALF) >>> 11;
  assign yaw_r   = (yaw_z + ROUND_HALF) >>> 11;

  always_comb begin
    roll_c = roll_r;
    if (roll_r > PI_Q13) roll_c = PI_Q13;
    if (roll_r < -PI_Q13) roll_c = -PI_Q13;
    yaw_c = yaw_r;
    if (yaw_r > PI_Q13) yaw_c = PI_Q13;
    if (yaw_r < -PI_Q13) yaw_c = -PI_Q13;
    pitch_c = pitch_r;
    if (pitch_r > HALF_PI_Q13) pitch_c = HALF_PI_Q13;
    if (pitch_r < -HALF_PI_Q13) pitch_c = -HALF_PI_Q13;
    if (sat_flags[1]) pitch_c = HALF_PI_Q13;
    if (sat_flags[0]) pitch_c = -HALF_PI_Q13;
  end

  always_ff @(posedge clk_i) begin
    roll_q  <= roll_c[15:0];
    pitch_q <= pitch_c[14:0];
    yaw_q   <= yaw_c[15:0];
    sat_q   <= sat_flags[1] || sat_flags[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cor_vld;
    end
  end

  assign done_o            = done_q;
  assign roll_angle_o      = roll_q;
  assign pitch_angle_o     = pitch_q;
  assign yaw_angle_o       = yaw_q;
  assign pitch_saturated_o = sat_q;

  // Every accepted item comes out after a fixed latency, and nothing else does.
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##LATENCY done_o)
    else $error("item lost in pipeline");

  a_no_phantom : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without an item");

  a_sat_pitch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && pitch_saturated_o |->
      (pitch_angle_o == 15'sd12868) || (pitch_angle_o == -15'sd12868))
    else $error("clamped pitch not at +-pi/2");

  a_roll_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (roll_angle_o <= 16'sd25736) && (roll_angle_o >= -16'sd25736)
               && (yaw_angle_o <= 16'sd25736) && (yaw_angle_o >= -16'sd25736))
    else $error("angle out of range");

endmodule
